### sv/arb_pkg.sv
// Shared constants, types and codes for the audio ring buffer.
package arb_pkg;

    localparam int DEPTH    = 1024;
    localparam int ADDR_W   = $clog2(DEPTH);
    localparam int PTR_W    = ADDR_W + 1;
    localparam int FRAME_W  = 64;
    localparam int LEN_W    = 11;
    localparam int REQ_W    = 7;
    localparam int MAX_READ = 64;
    localparam int K_W      = (MAX_READ > 1) ? $clog2(MAX_READ) : 1;
    localparam int CNT_W    = 32;
    localparam int LIMIT_W  = 13;
    localparam int TARGET_W = 11;
    localparam int KEEP_W   = TARGET_W + 1;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W    = 13;

    localparam logic [PTR_W-1:0]    DEPTH_P        = PTR_W'(DEPTH);
    localparam logic [REQ_W-1:0]    MAX_READ_P     = REQ_W'(MAX_READ);
    localparam logic [LIMIT_W-1:0]  LIMIT_RESET    = LIMIT_W'(512);
    localparam logic [TARGET_W-1:0] TARGET_RESET   = TARGET_W'(256);

    localparam logic [CFG_IDX_W-1:0] REG_BACKLOG_LIMIT = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL  = 1'd1;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_FRAME  = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_TRIM  = 4'b0010,
        ST_COUNT = 4'b0100,
        ST_EMIT  = 4'b1000
    } arb_state_t;

    typedef struct packed {
        logic wr;
        logic rd_load;
        logic trim;
        logic count;
        logic issue;
    } arb_cmd_t;

    typedef struct packed {
        logic emit_last;
    } arb_sts_t;

endpackage

### sv/arb_ram.sv
// Generic simple dual-port RAM with registered read data.
module arb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### sv/arb_ctrl.sv
// Controller state machine that sequences read requests.
module arb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               cmd,
    input  arb_pkg::arb_sts_t  sts,
    output arb_pkg::arb_cmd_t  ctl,
    output logic               busy
);

    arb_pkg::arb_state_t state_reg, state_next;
    logic accept;

    assign busy   = (state_reg != arb_pkg::ST_IDLE);
    assign accept = start && !busy;

    always_comb
    begin
        state_next    = state_reg;
        ctl           = '0;
        ctl.wr        = accept && (cmd == arb_pkg::CMD_WRITE);
        ctl.rd_load   = accept && (cmd == arb_pkg::CMD_READ);
        case (state_reg)
            arb_pkg::ST_IDLE:
            begin
                if (ctl.rd_load)
                begin
                    state_next = arb_pkg::ST_TRIM;
                end
            end
            arb_pkg::ST_TRIM:
            begin
                ctl.trim   = 1'b1;
                state_next = arb_pkg::ST_COUNT;
            end
            arb_pkg::ST_COUNT:
            begin
                ctl.count  = 1'b1;
                state_next = arb_pkg::ST_EMIT;
            end
            arb_pkg::ST_EMIT:
            begin
                ctl.issue = 1'b1;
                if (sts.emit_last)
                begin
                    state_next = arb_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = arb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= arb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### sv/arb_dp.sv
// Datapath: pointers, counters, configuration, frame store and result registers.
module arb_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  arb_pkg::arb_cmd_t             ctl,
    output arb_pkg::arb_sts_t             sts,
    input  logic                          cfg_we,
    input  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arb_pkg::CFG_W-1:0]     cfg_data,
    input  logic [arb_pkg::LEN_W-1:0]     block_frames,
    input  logic [arb_pkg::REQ_W-1:0]     request_frames,
    input  logic [arb_pkg::FRAME_W-1:0]   frame_data,
    output logic                          strobe,
    output logic                          kind,
    output logic                          block_accepted,
    output logic                          frame_valid,
    output logic [arb_pkg::FRAME_W-1:0]   frame_out,
    output logic                          last,
    output logic [arb_pkg::PTR_W-1:0]     frames_delivered,
    output logic [arb_pkg::PTR_W-1:0]     fill_level,
    output logic [arb_pkg::CNT_W-1:0]     dropped_total,
    output logic [arb_pkg::CNT_W-1:0]     missing_total,
    output logic [arb_pkg::CNT_W-1:0]     received_total
);

    localparam int PTR_W = arb_pkg::PTR_W;
    localparam int REQ_W = arb_pkg::REQ_W;
    localparam int CNT_W = arb_pkg::CNT_W;
    localparam int ADDR_W = arb_pkg::ADDR_W;

    logic [arb_pkg::LIMIT_W-1:0]  limit_reg, limit_next;
    logic [arb_pkg::TARGET_W-1:0] target_reg, target_next;
    logic [PTR_W-1:0] cwp_reg, cwp_next;
    logic [PTR_W-1:0] wwp_reg, wwp_next;
    logic [PTR_W-1:0] rp_reg, rp_next;
    logic [PTR_W-1:0] rem_reg, rem_next;
    logic             dropping_reg, dropping_next;
    logic [CNT_W-1:0] dropped_reg, dropped_next;
    logic [CNT_W-1:0] missing_reg, missing_next;
    logic [CNT_W-1:0] received_reg, received_next;
    logic [REQ_W-1:0] n_reg, n_next;
    logic [REQ_W-1:0] cnt_reg, cnt_next;
    logic [PTR_W-1:0] fill_reg, fill_next;
    logic [arb_pkg::KEEP_W-1:0] keep_reg, keep_next;
    logic [PTR_W-1:0] base_reg, base_next;
    logic [arb_pkg::K_W-1:0] k_reg, k_next;
    logic strobe_reg, strobe_next;
    logic kind_reg, kind_next;
    logic acc_reg, acc_next;
    logic valid_reg, valid_next;
    logic last_reg, last_next;
    logic [PTR_W-1:0] deliv_reg, deliv_next;

    logic                      ram_we;
    logic [ADDR_W-1:0]         ram_waddr;
    logic [ADDR_W-1:0]         ram_raddr;
    logic [arb_pkg::FRAME_W-1:0] ram_rdata;

    logic [PTR_W-1:0] fill_now;
    logic [REQ_W-1:0] k_ext;
    logic             emit_last;

    assign fill_now  = cwp_reg - rp_reg;
    assign k_ext     = REQ_W'(k_reg);
    assign emit_last = (k_ext == n_reg - REQ_W'(1));
    assign sts.emit_last = emit_last;

    always_comb
    begin
        logic             first;
        logic [PTR_W-1:0] len;
        logic             fit;
        logic             drop;
        logic [PTR_W-1:0] wptr;
        logic [PTR_W-1:0] rem;
        logic [PTR_W-1:0] rem_dec;
        logic [PTR_W-1:0] wptr_inc;
        logic [REQ_W-1:0] n_clamp;
        logic [REQ_W-1:0] count;
        logic [PTR_W-1:0] rd_addr;

        limit_next    = limit_reg;
        target_next   = target_reg;
        cwp_next      = cwp_reg;
        wwp_next      = wwp_reg;
        rp_next       = rp_reg;
        rem_next      = rem_reg;
        dropping_next = dropping_reg;
        dropped_next  = dropped_reg;
        missing_next  = missing_reg;
        received_next = received_reg;
        n_next        = n_reg;
        cnt_next      = cnt_reg;
        fill_next     = fill_reg;
        keep_next     = keep_reg;
        base_next     = base_reg;
        k_next        = k_reg;
        strobe_next   = 1'b0;
        kind_next     = kind_reg;
        acc_next      = acc_reg;
        valid_next    = valid_reg;
        last_next     = last_reg;
        deliv_next    = deliv_reg;
        ram_we        = 1'b0;

        if (cfg_we)
        begin
            case (cfg_index)
                arb_pkg::REG_BACKLOG_LIMIT: limit_next  = cfg_data;
                arb_pkg::REG_TARGET_LEVEL:  target_next = cfg_data[arb_pkg::TARGET_W-1:0];
                default: ;
            endcase
        end

        // Write frame: the fit check happens on a block's first frame only.
        first    = (rem_reg == '0);
        len      = (block_frames == '0) ? PTR_W'(1) : PTR_W'(block_frames);
        fit      = (fill_now <= arb_pkg::DEPTH_P) && (len <= arb_pkg::DEPTH_P - fill_now);
        drop     = first ? !fit : dropping_reg;
        wptr     = first ? cwp_reg : wwp_reg;
        rem      = first ? len : rem_reg;
        rem_dec  = rem - PTR_W'(1);
        wptr_inc = wptr + PTR_W'(1);
        ram_waddr = wptr[ADDR_W-1:0];

        if (ctl.wr)
        begin
            rem_next      = rem_dec;
            dropping_next = drop;
            if (!drop)
            begin
                ram_we   = 1'b1;
                wwp_next = wptr_inc;
            end
            if (first && drop)
            begin
                dropped_next = dropped_reg + CNT_W'(len);
            end
            if (rem_dec == '0)
            begin
                strobe_next   = 1'b1;
                kind_next     = arb_pkg::KIND_STATUS;
                acc_next      = !drop;
                valid_next    = 1'b0;
                last_next     = 1'b1;
                dropping_next = 1'b0;
                deliv_next    = '0;
                if (!drop)
                begin
                    cwp_next      = wptr_inc;
                    received_next = received_reg + CNT_W'(wptr_inc - cwp_reg);
                    deliv_next    = wptr_inc - cwp_reg;
                end
            end
        end

        n_clamp = (request_frames == '0) ? REQ_W'(1) :
                  (request_frames > arb_pkg::MAX_READ_P) ? arb_pkg::MAX_READ_P : request_frames;
        if (ctl.rd_load)
        begin
            n_next    = n_clamp;
            fill_next = fill_now;
            keep_next = arb_pkg::KEEP_W'(n_clamp) + arb_pkg::KEEP_W'(target_reg);
        end

        // Backlog trim: above the limit, only the newest keep frames are kept.
        if (ctl.trim)
        begin
            if ((arb_pkg::LIMIT_W'(fill_reg) > limit_reg) &&
                (arb_pkg::KEEP_W'(fill_reg) > keep_reg))
            begin
                dropped_next = dropped_reg + CNT_W'(fill_reg - keep_reg[PTR_W-1:0]);
                rp_next      = cwp_reg - keep_reg[PTR_W-1:0];
                fill_next    = keep_reg[PTR_W-1:0];
            end
        end

        count = (fill_reg < PTR_W'(n_reg)) ? REQ_W'(fill_reg) : n_reg;
        if (ctl.count)
        begin
            cnt_next     = count;
            base_next    = rp_reg;
            rp_next      = rp_reg + PTR_W'(count);
            missing_next = missing_reg + CNT_W'(n_reg - count);
            deliv_next   = PTR_W'(count);
            k_next       = '0;
        end

        rd_addr   = base_reg + PTR_W'(k_reg);
        ram_raddr = rd_addr[ADDR_W-1:0];
        if (ctl.issue)
        begin
            strobe_next = 1'b1;
            kind_next   = arb_pkg::KIND_FRAME;
            acc_next    = 1'b0;
            valid_next  = (k_ext < cnt_reg);
            last_next   = emit_last;
            k_next      = k_reg + arb_pkg::K_W'(1);
        end
    end

    arb_ram #(
        .WIDTH (arb_pkg::FRAME_W),
        .DEPTH (arb_pkg::DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (frame_data),
        .re    (ctl.issue),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg    <= arb_pkg::LIMIT_RESET;
            target_reg   <= arb_pkg::TARGET_RESET;
            cwp_reg      <= '0;
            wwp_reg      <= '0;
            rp_reg       <= '0;
            rem_reg      <= '0;
            dropping_reg <= 1'b0;
            dropped_reg  <= '0;
            missing_reg  <= '0;
            received_reg <= '0;
            k_reg        <= '0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            limit_reg    <= limit_next;
            target_reg   <= target_next;
            cwp_reg      <= cwp_next;
            wwp_reg      <= wwp_next;
            rp_reg       <= rp_next;
            rem_reg      <= rem_next;
            dropping_reg <= dropping_next;
            dropped_reg  <= dropped_next;
            missing_reg  <= missing_next;
            received_reg <= received_next;
            k_reg        <= k_next;
            strobe_reg   <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        cnt_reg   <= cnt_next;
        fill_reg  <= fill_next;
        keep_reg  <= keep_next;
        base_reg  <= base_next;
        kind_reg  <= kind_next;
        acc_reg   <= acc_next;
        valid_reg <= valid_next;
        last_reg  <= last_next;
        deliv_reg <= deliv_next;
    end

    assign strobe           = strobe_reg;
    assign kind             = kind_reg;
    assign block_accepted   = acc_reg;
    assign frame_valid      = valid_reg;
    assign frame_out        = valid_reg ? ram_rdata : '0;
    assign last             = last_reg;
    assign frames_delivered = deliv_reg;
    assign fill_level       = fill_now;
    assign dropped_total    = dropped_reg;
    assign missing_total    = missing_reg;
    assign received_total   = received_reg;

endmodule

### sv/audio_ring_buffer_with_backlog_trim.sv
// Top level of the audio ring buffer with backlog trim.
//
//  Channel  | Handshake            | Payload
//  ---------+----------------------+--------------------------------------------
//  command  | start, busy          | cmd, block_frames, request_frames, frame_data
//  result   | strobe (one cycle)   | kind, block_accepted, frame_valid, frame_out,
//           |                      | last, frames_delivered, fill_level, totals
//  config   | cfg_we               | cfg_index, cfg_data
//
// Write frames leave busy low, so they stream at one per cycle unless a read holds busy;
// a block's status result appears in the cycle after its last frame.
// A read request for N frames keeps busy high through a trim state, a count state, then
// one frame store read per frame, each result registered in the cycle after its read.
// Reset clears pointers, counters and control; the frame store is not cleared.
// Results cannot be stalled: each one is valid for the single cycle strobe is high.
module audio_ring_buffer_with_backlog_trim (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          cmd,
    input  logic [arb_pkg::LEN_W-1:0]     block_frames,
    input  logic [arb_pkg::REQ_W-1:0]     request_frames,
    input  logic [arb_pkg::FRAME_W-1:0]   frame_data,
    input  logic                          cfg_we,
    input  logic [arb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [arb_pkg::CFG_W-1:0]     cfg_data,
    output logic                          strobe,
    output logic                          kind,
    output logic                          block_accepted,
    output logic                          frame_valid,
    output logic [arb_pkg::FRAME_W-1:0]   frame_out,
    output logic                          last,
    output logic [arb_pkg::PTR_W-1:0]     frames_delivered,
    output logic [arb_pkg::PTR_W-1:0]     fill_level,
    output logic [arb_pkg::CNT_W-1:0]     dropped_total,
    output logic [arb_pkg::CNT_W-1:0]     missing_total,
    output logic [arb_pkg::CNT_W-1:0]     received_total
);

    arb_pkg::arb_cmd_t ctl;
    arb_pkg::arb_sts_t sts;

    arb_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (cmd),
        .sts   (sts),
        .ctl   (ctl),
        .busy  (busy)
    );

    arb_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .ctl              (ctl),
        .sts              (sts),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .block_frames     (block_frames),
        .request_frames   (request_frames),
        .frame_data       (frame_data),
        .strobe           (strobe),
        .kind             (kind),
        .block_accepted   (block_accepted),
        .frame_valid      (frame_valid),
        .frame_out        (frame_out),
        .last             (last),
        .frames_delivered (frames_delivered),
        .fill_level       (fill_level),
        .dropped_total    (dropped_total),
        .missing_total    (missing_total),
        .received_total   (received_total)
    );

`ifndef NO_ASSERTIONS
    // The frames of one read transaction come out on consecutive cycles.
    a_read_burst: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == arb_pkg::KIND_FRAME) && !last |=>
            strobe && (kind == arb_pkg::KIND_FRAME))
        else $error("read results not contiguous");

    // The committed fill never exceeds the store depth.
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_level <= arb_pkg::DEPTH_P)
        else $error("fill level above depth");

    // A block status follows directly on an accepted write frame.
    a_status_origin: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == arb_pkg::KIND_STATUS) |->
            $past(start && !busy && (cmd == arb_pkg::CMD_WRITE)))
        else $error("status without a write transaction");

    // No read result while a new transaction could be accepted, except the final one.
    a_busy_during_read: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && (kind == arb_pkg::KIND_FRAME) && !last |-> busy)
        else $error("idle during read results");
`endif

endmodule
